// ===== src/ffdp_pkg.sv =====
`default_nettype none
package ffdp_pkg;

  localparam logic [7:0] HDR1 = 8'hAA;
  localparam logic [7:0] HDR2 = 8'h55;
  localparam logic [7:0] GYRO_TAG = 8'h0D;
  localparam logic [5:0] NO_CODE = 6'h3F;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_CSUM = 4'd1;
  localparam logic [3:0] ST_GYRO_LEN = 4'd9;

  localparam logic [5:0] Q_FRAME_ID = 6'd28;
  localparam logic [5:0] Q_GYRO_X = 6'd29;

  typedef struct packed {
    logic       known;
    logic [7:0] len;
    logic [3:0] err;
  } tag_info_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] width;
    logic [2:0] off;
    logic [5:0] code;
    logic [7:0] mask;
  } field_info_t;

  function automatic tag_info_t tag_lookup(input logic [7:0] t);
    tag_info_t r;
    r = '{known: 1'b1, len: 8'd0, err: 4'd0};
    unique case (t)
      8'h01: begin r.len = 8'd15; r.err = 4'd2; end
      8'h03: begin r.len = 8'd3; r.err = 4'd3; end
      8'h04: begin r.len = 8'd7; r.err = 4'd4; end
      8'h05: begin r.len = 8'd6; r.err = 4'd5; end
      8'h06: begin r.len = 8'd2; r.err = 4'd6; end
      8'h0A: begin r.len = 8'd4; r.err = 4'd7; end
      8'h0B: begin r.len = 8'd4; r.err = 4'd8; end
      8'h10: begin r.len = 8'd16; r.err = 4'd10; end
      8'h13: begin r.len = 8'd12; r.err = 4'd11; end
      default: r.known = 1'b0;
    endcase
    return r;
  endfunction

  // field of a known tag that covers body byte k
  function automatic field_info_t field_lookup(input logic [7:0] t, input logic [7:0] k);
    field_info_t f;
    f = '{hit: 1'b1, width: 3'd1, off: 3'd0, code: NO_CODE, mask: 8'hFF};
    unique case (t)
      8'h01: begin
        unique case (k)
          8'd0: begin f.width = 3'd2; f.code = 6'd0; end
          8'd1: begin f.width = 3'd2; f.off = 3'd1; f.code = 6'd0; end
          8'd2: begin f.code = 6'd1; f.mask = 8'h07; end
          8'd3: begin f.code = 6'd2; f.mask = 8'h03; end
          8'd4: begin f.code = 6'd3; f.mask = 8'h07; end
          8'd5: begin f.width = 3'd2; f.code = 6'd4; end
          8'd6: begin f.width = 3'd2; f.off = 3'd1; f.code = 6'd4; end
          8'd7: begin f.width = 3'd2; f.code = 6'd5; end
          8'd8: begin f.width = 3'd2; f.off = 3'd1; f.code = 6'd5; end
          8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14:
            f.code = 6'(k - 8'd3);
          default: f.hit = 1'b0;
        endcase
      end
      8'h03: begin
        if (k < 8'd3) f.code = 6'(k + 8'd12);
        else f.hit = 1'b0;
      end
      8'h04: begin
        if (k < 8'd4) begin
          f.width = 3'd2; f.off = {2'b0, k[0]}; f.code = 6'd15 + {5'b0, k[1]};
        end else if (k >= 8'd7) f.hit = 1'b0;
      end
      8'h05: begin
        if (k < 8'd6) begin
          f.width = 3'd2; f.off = {2'b0, k[0]}; f.code = 6'd17 + {4'b0, k[2:1]};
        end else f.hit = 1'b0;
      end
      8'h06: begin
        if (k < 8'd2) f.code = 6'd20 + {5'b0, k[0]};
        else f.hit = 1'b0;
      end
      8'h0A, 8'h0B: begin
        if (k < 8'd3) f.code = ((t == 8'h0A) ? 6'd22 : 6'd25) + {4'b0, k[1:0]};
        else if (k >= 8'd4) f.hit = 1'b0;
      end
      8'h10: begin
        if (k < 8'd10) begin
          f.width = 3'd2; f.off = {2'b0, k[0]}; f.code = 6'd32 + {2'b0, k[4:1]};
        end else if (k >= 8'd16) f.hit = 1'b0;
      end
      8'h13: begin
        if (k < 8'd12) begin
          f.width = 3'd4; f.off = {1'b0, k[1:0]}; f.code = 6'd37 + {4'b0, k[3:2]};
        end else f.hit = 1'b0;
      end
      default: f.hit = 1'b0;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] sat8(input logic [10:0] v);
    return (v > 11'd255) ? 8'hFF : v[7:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/ffdp_out_reg.sv =====
`default_nettype none
module ffdp_out_reg
  import ffdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic        d_end,
  input  wire logic [5:0]  d_qty,
  input  wire logic [31:0] d_val,
  input  wire logic [3:0]  d_st,
  output logic             full,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_frame_end,
  output logic [5:0]       out_quantity,
  output logic [31:0]      out_value,
  output logic [3:0]       out_frame_status
);
  // two-entry buffer: main register plus skid
  logic        v0_r, v1_r;
  logic [42:0] m_r, s_r;
  logic        pop;

  assign pop = v0_r && !out_stall;
  assign full = v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (pop) begin
        if (v1_r) begin
          m_r <= s_r;
          if (push) s_r <= {d_end, d_qty, d_val, d_st};
          else v1_r <= 1'b0;
        end else if (push) m_r <= {d_end, d_qty, d_val, d_st};
        else v0_r <= 1'b0;
      end else if (push) begin
        if (v0_r) begin
          s_r <= {d_end, d_qty, d_val, d_st};
          v1_r <= 1'b1;
        end else begin
          m_r <= {d_end, d_qty, d_val, d_st};
          v0_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid = v0_r;
  assign {out_is_frame_end, out_quantity, out_value, out_frame_status} = m_r;
endmodule
`default_nettype wire

// ===== src/feedback_frame_deframer_parser_top.sv =====
`default_nettype none
// Serial frame deframer and tagged sub-payload parser.
// Input channel: one received byte per item (in_valid, in_stall, in_rx_byte).
// Bytes are searched for the header AA 55; then comes the length byte, the
// payload and an XOR checksum byte.
// Result channel: out_is_frame_end=0 items carry a decoded little-endian
// value with its quantity code; out_is_frame_end=1 items carry the frame
// status (ok, checksum error, or first sub-payload length error).
// Decoded values of a frame are only valid if its status reads ok.
// Each byte is parsed combinationally and its result is registered in a
// two-entry output buffer; one byte is accepted every cycle while that
// buffer is not full. The buffer holds results while the receiver
// stalls; in_stall rises only when that buffer is full.
// Synchronous reset returns the parser to header hunt and empties the buffer.
module feedback_frame_deframer_parser_top
  import ffdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_frame_end,
  output logic [5:0]       out_quantity,
  output logic [31:0]      out_value,
  output logic [3:0]       out_frame_status
);
  typedef enum logic [2:0] {PH_HUNT, PH_HDR2, PH_LEN, PH_BODY, PH_SUBLEN} phase_t;

  phase_t      ph_r, ph_nxt;
  logic [7:0]  flen_r, flen_nxt, par_r, par_nxt, poff_r, poff_nxt;
  logic [7:0]  nho_r, nho_nxt, tag_r, tag_nxt, fpos_r, fpos_nxt;
  logic [8:0]  brem_r, brem_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [6:0]  gyl_r, gyl_nxt;
  logic [3:0]  ferr_r, ferr_nxt;
  logic        stop_r, stop_nxt;

  logic        full, acc_in, e_v, e_end;
  logic [5:0]  e_q;
  logic [31:0] e_val;
  logic [3:0]  e_st;
  logic [7:0]  b, k, po, j;
  logic [8:0]  br;
  tag_info_t   ti;
  field_info_t fi;
  logic [6:0]  g3;
  logic [15:0] g3_prod;
  logic [7:0]  gx, gyro_j;
  logic [15:0] gx_prod;
  logic [31:0] sh;

  assign in_stall = full;
  assign acc_in = in_valid && !full;
  assign b = in_rx_byte;
  assign ti = tag_lookup(tag_r);
  assign fi = field_lookup(tag_r, fpos_r);
  // divide by 3 through reciprocal multiply, exact for any byte
  assign g3_prod = {8'b0, b} * 16'd171;
  assign g3 = g3_prod[15:9];
  // position within a six-byte gyro sample
  assign gx = fpos_r - 8'd2;
  assign gx_prod = {8'b0, gx} * 16'd171;
  assign gyro_j = gx - {2'b0, gx_prod[15:10]} * 8'd6;

  always_comb begin
    ph_nxt = ph_r; flen_nxt = flen_r; par_nxt = par_r; poff_nxt = poff_r;
    nho_nxt = nho_r; tag_nxt = tag_r; fpos_nxt = fpos_r; brem_nxt = brem_r;
    acc_nxt = acc_r; gyl_nxt = gyl_r; ferr_nxt = ferr_r; stop_nxt = stop_r;
    e_v = 1'b0; e_end = 1'b0; e_q = '0; e_val = '0; e_st = '0;
    k = fpos_r; po = poff_r; br = brem_r; j = '0; sh = '0;
    unique case (ph_r)
      PH_HUNT: if (b == HDR1) ph_nxt = PH_HDR2;
      PH_HDR2: ph_nxt = (b == HDR2) ? PH_LEN : PH_HUNT;
      PH_LEN: begin
        flen_nxt = b; par_nxt = b; brem_nxt = {1'b0, b} + 9'd1;
        poff_nxt = '0; nho_nxt = 8'd1; tag_nxt = '0; fpos_nxt = '0;
        acc_nxt = '0; gyl_nxt = '0; ferr_nxt = ST_OK; stop_nxt = 1'b0;
        ph_nxt = PH_BODY;
      end
      PH_BODY, PH_SUBLEN: begin
        par_nxt = par_r ^ b;
        if (br != 9'd0) br = br - 9'd1;
        brem_nxt = br;
        if (br == 9'd0) begin
          e_v = 1'b1; e_end = 1'b1;
          e_st = (par_nxt != 8'd0) ? ST_CSUM : ferr_r;
          ph_nxt = PH_HUNT;
        end else begin
          if (po != 8'hFF) po = po + 8'd1;
          poff_nxt = po;
          if (stop_r) begin
          end else if (po == nho_r) begin
            if (po < flen_r) begin
              tag_nxt = b; fpos_nxt = '0; acc_nxt = '0; gyl_nxt = '0;
              ph_nxt = PH_SUBLEN;
            end
          end else if (ph_r == PH_SUBLEN) begin
            ph_nxt = PH_BODY;
            if (tag_r == GYRO_TAG) begin
              if (b[0]) begin ferr_nxt = ST_GYRO_LEN; stop_nxt = 1'b1; end
              else nho_nxt = sat8({3'b0, po} + 11'd3);
            end else if (ti.known) begin
              if (b != ti.len) begin ferr_nxt = ti.err; stop_nxt = 1'b1; end
              else nho_nxt = sat8({3'b0, po} + 11'd1 + {3'b0, ti.len});
            end else nho_nxt = sat8({3'b0, po} + 11'd1 + {3'b0, b});
          end else begin
            if (fpos_r != 8'hFF) fpos_nxt = fpos_r + 8'd1;
            if (tag_r == GYRO_TAG) begin
              if (k == 8'd0) begin
                e_v = 1'b1; e_q = Q_FRAME_ID; e_val = {24'b0, b};
              end else if (k == 8'd1) begin
                gyl_nxt = g3;
                nho_nxt = sat8({3'b0, po} + 11'd1 + 11'(g3) * 11'd6);
              end else if (gyl_r != 7'd0) begin
                j = gyro_j;
                if (!j[0]) acc_nxt = {24'b0, b};
                else begin
                  acc_nxt = acc_r | {16'b0, b, 8'b0};
                  if (j == 8'd5) gyl_nxt = gyl_r - 7'd1;
                  e_v = 1'b1; e_q = Q_GYRO_X + 6'(j >> 1);
                  e_val = {16'b0, acc_nxt[15:0]};
                end
              end
            end else if (fi.hit && fi.code != NO_CODE) begin
              sh = {24'b0, b} << {fi.off[1:0], 3'b0};
              acc_nxt = ((fi.off == 3'd0) ? 32'd0 : acc_r) | sh;
              if (fi.off + 3'd1 == fi.width) begin
                e_v = 1'b1; e_q = fi.code;
                e_val = (fi.width == 3'd1) ? (acc_nxt & {24'b0, fi.mask}) : acc_nxt;
              end
            end
          end
        end
      end
      default: ph_nxt = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HUNT; flen_r <= '0; par_r <= '0; poff_r <= '0; nho_r <= 8'd1;
      tag_r <= '0; fpos_r <= '0; brem_r <= '0; acc_r <= '0; gyl_r <= '0;
      ferr_r <= ST_OK; stop_r <= 1'b0;
    end else if (acc_in) begin
      ph_r <= ph_nxt; flen_r <= flen_nxt; par_r <= par_nxt; poff_r <= poff_nxt;
      nho_r <= nho_nxt; tag_r <= tag_nxt; fpos_r <= fpos_nxt; brem_r <= brem_nxt;
      acc_r <= acc_nxt; gyl_r <= gyl_nxt; ferr_r <= ferr_nxt; stop_r <= stop_nxt;
    end
  end

  ffdp_out_reg u_out (
    .clk(clk), .rst_n(rst_n), .push(acc_in && e_v),
    .d_end(e_end), .d_qty(e_q), .d_val(e_val), .d_st(e_st), .full(full),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_is_frame_end(out_is_frame_end), .out_quantity(out_quantity),
    .out_value(out_value), .out_frame_status(out_frame_status)
  );
endmodule
`default_nettype wire

// ===== src/ffdp_checker.sv =====
`default_nettype none
module ffdp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_is_frame_end,
  input wire logic [5:0]  out_quantity,
  input wire logic [31:0] out_value,
  input wire logic [3:0]  out_frame_status
);
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_frame_end |-> out_quantity == 6'd0 && out_value == 32'd0)
    else $error("status item with nonzero value fields");
  a_value_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_frame_end |-> out_frame_status == 4'd0 && out_quantity <= 6'd39)
    else $error("bad value item");
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value))
    else $error("stalled result changed");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not empty after reset");
endmodule

bind feedback_frame_deframer_parser_top ffdp_checker u_chk (.*);
`default_nettype wire

// ===== tb/tb_feedback_frame_deframer_parser_top.sv =====
`default_nettype none
module tb_feedback_frame_deframer_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {P_HUNT, P_HDR2, P_LEN, P_BODY, P_SUBLEN} link_phase_t;

  typedef struct packed {
    logic        is_end;
    logic [5:0]  qty;
    logic [31:0] val;
    logic [3:0]  st;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_is_frame_end;
  logic [5:0]  out_quantity;
  logic [31:0] out_value;
  logic [3:0]  out_frame_status;

  feedback_frame_deframer_parser_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_is_frame_end(out_is_frame_end), .out_quantity(out_quantity),
    .out_value(out_value), .out_frame_status(out_frame_status)
  );

  always #6 clk = ~clk;

  // sub-payload layout tables
  int unsigned tg_tag[9]   = '{8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h0A, 8'h0B, 8'h10, 8'h13};
  int unsigned tg_len[9]   = '{15, 3, 7, 6, 2, 4, 4, 16, 12};
  int unsigned tg_err[9]   = '{2, 3, 4, 5, 6, 7, 8, 10, 11};
  int unsigned tg_first[9] = '{0, 12, 15, 18, 21, 23, 27, 31, 37};
  int unsigned tg_cnt[9]   = '{12, 3, 3, 3, 2, 4, 4, 6, 3};
  int unsigned fw[40] = '{2,1,1,1,2,2,1,1,1,1,1,1, 1,1,1, 2,2,3, 2,2,2, 1,1,
                          1,1,1,1, 1,1,1,1, 2,2,2,2,2,6, 4,4,4};
  int unsigned fc[40] = '{0,1,2,3,4,5,6,7,8,9,10,11, 12,13,14, 15,16,63, 17,18,19,
                          20,21, 22,23,24,63, 25,26,27,63, 32,33,34,35,36,63, 37,38,39};
  int unsigned fm[40] = '{255,7,3,7,255,255,255,255,255,255,255,255,
                          255,255,255,255,255,255,255,255,255,255,255,
                          255,255,255,255,255,255,255,255,255,255,255,255,255,255,
                          255,255,255};

  // predictor state
  link_phase_t ph;
  logic [7:0]  flen, par, poff, nho, ctag, fpos, ferr;
  logic [8:0]  brem;
  logic [31:0] acc;
  logic [6:0]  gleft;
  logic        pstop;

  parse_result_t expected_results[$];
  logic [7:0]    rx_bytes[$];
  int            fails = 0;
  int            accepted = 0;
  int            n_total = 1;

  function automatic int tag_index(input logic [7:0] t);
    for (int i = 0; i < 9; i++) if (tg_tag[i] == t) return i;
    return -1;
  endfunction

  function automatic logic [7:0] sat(input int unsigned v);
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic void push_value(input logic [5:0] q, input logic [31:0] v);
    parse_result_t r;
    r = '{is_end: 1'b0, qty: q, val: v, st: 4'd0};
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void body_byte(input logic [7:0] b);
    int unsigned k, start, j, ti, fi, off;
    k = fpos;
    if (fpos < 255) fpos++;
    if (ctag == ffdp_pkg::GYRO_TAG) begin
      if (k == 0) begin push_value(ffdp_pkg::Q_FRAME_ID, b); return; end
      if (k == 1) begin
        gleft = 7'(b / 3);
        nho = sat(poff + 1 + 6 * gleft);
        return;
      end
      if (gleft == 0) return;
      j = (k - 2) % 6;
      if (j[0] == 1'b0) begin acc = b; return; end
      acc |= 32'(b) << 8;
      if (j == 5) gleft--;
      push_value(6'(ffdp_pkg::Q_GYRO_X + j / 2), acc & 32'hFFFF);
      return;
    end
    if (tag_index(ctag) < 0) return;
    ti = tag_index(ctag);
    start = 0;
    for (int i = 0; i < tg_cnt[ti]; i++) begin
      fi = tg_first[ti] + i;
      if (k < start + fw[fi]) begin
        off = k - start;
        if (fc[fi] == ffdp_pkg::NO_CODE) return;
        if (off == 0) acc = 0;
        acc |= 32'(b) << (8 * off);
        if (off + 1 == fw[fi]) push_value(6'(fc[fi]), (fw[fi] == 1) ? (acc & fm[fi]) : acc);
        return;
      end
      start += fw[fi];
    end
  endfunction

  function automatic void payload_byte(input logic [7:0] b);
    int ti;
    if (pstop) return;
    if (poff == nho) begin
      if (poff < flen) begin
        ctag = b; fpos = 0; acc = 0; gleft = 0; ph = P_SUBLEN;
      end
      return;
    end
    if (ph == P_SUBLEN) begin
      ti = tag_index(ctag);
      ph = P_BODY;
      if (ctag == ffdp_pkg::GYRO_TAG) begin
        if (b[0]) begin ferr = ffdp_pkg::ST_GYRO_LEN; pstop = 1'b1; return; end
        nho = sat(poff + 3);
      end else if (ti >= 0) begin
        if (b != tg_len[ti]) begin ferr = tg_err[ti]; pstop = 1'b1; return; end
        nho = sat(poff + 1 + tg_len[ti]);
      end else begin
        nho = sat(poff + 1 + b);
      end
      return;
    end
    body_byte(b);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    parse_result_t r;
    case (ph)
      P_HUNT: if (b == ffdp_pkg::HDR1) ph = P_HDR2;
      P_HDR2: ph = (b == ffdp_pkg::HDR2) ? P_LEN : P_HUNT;
      P_LEN: begin
        flen = b; par = b; brem = 9'(b) + 9'd1; poff = 0; nho = 1; ctag = 0;
        fpos = 0; acc = 0; gleft = 0; ferr = 0; pstop = 0; ph = P_BODY;
      end
      P_BODY, P_SUBLEN: begin
        par ^= b;
        if (brem > 0) brem--;
        if (brem == 0) begin
          r = '{is_end: 1'b1, qty: 6'd0, val: 32'd0,
                st: (par != 0) ? ffdp_pkg::ST_CSUM : ferr[3:0]};
          expected_results.insert(expected_results.size(), r);
          ph = P_HUNT;
        end else begin
          if (poff < 255) poff++;
          payload_byte(b);
        end
      end
      default: ph = P_HUNT;
    endcase
  endfunction

  // stimulus builders
  task automatic add_frame(input logic [7:0] pl[$], input bit bad_sum);
    logic [7:0] cs;
    while (pl.size() > 255) void'(pl.pop_back());
    cs = 8'(pl.size());
    rx_bytes.insert(rx_bytes.size(), ffdp_pkg::HDR1);
    rx_bytes.insert(rx_bytes.size(), ffdp_pkg::HDR2);
    rx_bytes.insert(rx_bytes.size(), 8'(pl.size()));
    foreach (pl[i]) begin rx_bytes.insert(rx_bytes.size(), pl[i]); cs ^= pl[i]; end
    if (bad_sum) cs ^= 8'(1 << $urandom_range(0, 7));
    rx_bytes.insert(rx_bytes.size(), cs);
  endtask

  // kind 0..8 known tags, 9 gyro, 10 unknown
  task automatic add_sub(inout logic [7:0] pl[$], input int kind, input bit bad_len);
    int unsigned len, n;
    if (kind == 9) begin
      n = $urandom_range(0, 3);
      len = 2 + 6 * n;
      pl.insert(pl.size(), ffdp_pkg::GYRO_TAG);
      pl.insert(pl.size(), bad_len ? 8'(len | 1) : 8'(len));
      pl.insert(pl.size(), 8'($urandom));
      pl.insert(pl.size(), 8'(3 * n + $urandom_range(0, 2)));
      repeat (6 * n) pl.insert(pl.size(), 8'($urandom));
      return;
    end
    if (kind == 10) begin
      len = $urandom_range(0, 5);
      pl.insert(pl.size(), 8'($urandom_range(8'h14, 8'hFF)));
      pl.insert(pl.size(), 8'(len));
    end else begin
      len = tg_len[kind];
      pl.insert(pl.size(), 8'(tg_tag[kind]));
      pl.insert(pl.size(), bad_len ? 8'(len + $urandom_range(1, 3)) : 8'(len));
    end
    repeat (len) pl.insert(pl.size(), 8'($urandom));
  endtask

  task automatic build_stimulus();
    logic [7:0] pl[$];
    // every sub-payload kind in one good frame
    for (int k = 0; k <= 10; k++) add_sub(pl, k, 1'b0);
    add_frame(pl, 1'b0);
    pl = {};
    // bad second header byte, repeated first header byte
    rx_bytes.insert(rx_bytes.size(), 8'hAA); rx_bytes.insert(rx_bytes.size(), 8'hAA);
    rx_bytes.insert(rx_bytes.size(), 8'h55);
    rx_bytes.insert(rx_bytes.size(), 8'h00);
    // empty frame, then checksum error
    add_frame(pl, 1'b0);
    add_sub(pl, 0, 1'b0); add_frame(pl, 1'b1); pl = {};
    // length error followed by more tags, and length error with bad checksum
    add_sub(pl, 3, 1'b1); add_sub(pl, 1, 1'b0); add_frame(pl, 1'b0); pl = {};
    add_sub(pl, 9, 1'b1); add_frame(pl, 1'b1); pl = {};
    // value cut off by end of payload
    add_sub(pl, 8, 1'b0); void'(pl.pop_back()); void'(pl.pop_back());
    add_frame(pl, 1'b0); pl = {};
    // tag on last payload byte
    add_sub(pl, 4, 1'b0); pl.insert(pl.size(), 8'h01); add_frame(pl, 1'b0); pl = {};
    // far next header, max length frame
    pl.insert(pl.size(), 8'h40); pl.insert(pl.size(), 8'hFF);
    repeat (253) pl.insert(pl.size(), 8'($urandom));
    add_frame(pl, 1'b0); pl = {};
    pl.insert(pl.size(), 8'h01); pl.insert(pl.size(), 8'hFF); add_frame(pl, 1'b0); pl = {};
    // random traffic up to about 850 bytes including the closing run
    while (rx_bytes.size() < 590) begin
      if ($urandom_range(0, 99) < 80) begin
        repeat ($urandom_range(1, 4))
          add_sub(pl, $urandom_range(0, 10), $urandom_range(0, 99) < 8);
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 6)) if (pl.size() > 0) void'(pl.pop_back());
        add_frame(pl, $urandom_range(0, 9) == 0);
        pl = {};
      end else begin
        repeat ($urandom_range(1, 5))
          rx_bytes.insert(rx_bytes.size(),
                          $urandom_range(0, 3) == 0 ? 8'hAA : 8'($urandom));
      end
    end
    // close any frame left open by noise
    repeat (260) rx_bytes.insert(rx_bytes.size(), 8'h00);
  endtask

  function automatic int sender_idle_pct();
    case (accepted * 3 / n_total)
      0: return 21;
      1: return 80;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (accepted * 3 / n_total)
      0: return 80;
      1: return 21;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(in_rx_byte);
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (rx_bytes.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    parse_result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result end=%0d q=%0d v=%h st=%0d", $realtime,
                   out_is_frame_end, out_quantity, out_value, out_frame_status);
          fails++;
        end else begin
          e = expected_results.pop_front();
          if (e.is_end !== out_is_frame_end || e.qty !== out_quantity ||
              e.val !== out_value || e.st !== out_frame_status) begin
            $display("%0t mismatch expected end=%0d q=%0d v=%h st=%0d actual end=%0d q=%0d v=%h st=%0d",
                     $realtime, e.is_end, e.qty, e.val, e.st,
                     out_is_frame_end, out_quantity, out_value, out_frame_status);
            fails++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
    end
  end

  initial begin
    ph = P_HUNT; flen = 0; brem = 0; par = 0; poff = 0; nho = 1; ctag = 0;
    fpos = 0; acc = 0; gleft = 0; ferr = 0; pstop = 0;
    build_stimulus();
    n_total = rx_bytes.size();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (rx_bytes.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (expected_results.size() > 0)
        $display("%0t %0d expected results never arrived", $realtime, expected_results.size());
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
